// ===== hdl/tcpacr_pkg.sv =====
package tcpacr_pkg;

    localparam int unsigned MSS_W      = 16;
    localparam int unsigned RTTVAR_W   = 15;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DIV_CNT_W  = 5;

    localparam logic [7:0] DUP_THRESHOLD     = 8'd3;
    localparam logic [7:0] DUP_COUNT_MAX     = 8'd255;

    localparam logic [1:0] CMD_SEGMENT   = 2'd0;
    localparam logic [1:0] CMD_RTT_START = 2'd1;
    localparam logic [1:0] CMD_INIT      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MSS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RTTVAR = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_GROW,
        ST_RTT_A,
        ST_RTT_B,
        ST_OUT
    } tcpacr_state_t;

    // True when sequence a lies before sequence b in modulo 2^32 space.
    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    // Saturating add of a 32 bit window and a 33 bit increment.
    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [32:0] b);
        logic [33:0] sum;
        sum = {2'b00, a} + {1'b0, b};
        return (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

// ===== hdl/tcp_ack_congestion_rtt_update.sv =====
// Channel   Direction  Handshake                Contents
// s_        in         s_valid / s_ready        command and segment fields
// m_        out        m_valid / m_ready        windows, timeout, event flags
// cfg_      in         cfg_wr_en (no wait)      max segment size, initial variance
//
// One transaction is processed at a time; s_ready is high only when idle.
// A command goes from EXEC to OUT; a segment with ACK set also passes RTT_A, and
// first DIV and GROW when congestion avoidance runs the 32 step restoring divider.
// The divider loop and the two step RTT update set the latency.
// Reset (aresetn low, synchronous) clears all connection state.
// A result held by a low m_ready stalls the block until it is taken.
module tcp_ack_congestion_rtt_update (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [tcpacr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcpacr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_command,
    input  logic [31:0]                          s_seq_number,
    input  logic [31:0]                          s_ack_number,
    input  logic [15:0]                          s_window,
    input  logic                                 s_ack_flag,
    input  logic [31:0]                          s_highest_sent,
    input  logic                                 s_unacked_present,
    input  logic                                 s_connection_established,
    input  logic [31:0]                          s_now_tick,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [15:0]                          m_send_window,
    output logic [31:0]                          m_congestion_window,
    output logic [31:0]                          m_slow_start_threshold,
    output logic signed [15:0]                   m_retransmit_timeout,
    output logic [15:0]                          m_acked_bytes,
    output logic                                 m_fast_retransmit,
    output logic                                 m_new_data_acked,
    output logic                                 m_window_updated,
    output logic                                 m_rtt_sampled
);
    import tcpacr_pkg::*;

    tcpacr_state_t state_reg, state_next;

    // Configuration registers.
    logic [MSS_W-1:0]    mss_reg, mss_next;
    logic [RTTVAR_W-1:0] ivar_reg, ivar_next;

    // Captured transaction fields.
    logic [1:0]  cmd_reg;
    logic [31:0] seq_in_reg, ack_in_reg, snd_max_reg, now_reg;
    logic [15:0] wnd_reg;
    logic        ackf_reg, unacked_reg, est_reg;

    // Connection state.
    logic [15:0] pw_reg, pw_next;
    logic [31:0] wsm_reg, wsm_next, wam_reg, wam_next, last_reg, last_next;
    logic [7:0]  dc_reg, dc_next;
    logic [31:0] cw_reg, cw_next, ss_reg, ss_next;
    logic        rec_reg, rec_next;
    logic [15:0] srtt_reg, srtt_next, var_reg, var_next, rto_reg, rto_next;
    logic        ract_reg, ract_next;
    logic [31:0] rseq_reg, rseq_next, rtick_reg, rtick_next;

    // Divider and scratch registers.
    logic [31:0]          divq_reg, divq_next, divr_reg, divr_next, divd_reg, divd_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]          mabs_reg, mabs_next;

    // Result flags.
    logic [15:0] acked_reg, acked_next;
    logic        fast_reg, fast_next, newack_reg, newack_next;
    logic        wupd_reg, wupd_next, samp_reg, samp_next;

    logic        accept;
    assign accept = s_valid && s_ready;

    // Shared arithmetic terms.
    logic signed [15:0] srtt_s, var_s, srtt_sh, var_sh, srtt_n_s;
    logic [15:0]        base_rto;
    logic [31:0]        cw0, half, elapsed;
    logic [16:0]        floor2;
    logic [17:0]        mss3;
    logic [7:0]         dc_inc;
    logic [32:0]        rem_sh;
    logic signed [33:0] m_val, m_abs;
    logic [15:0]        var_n;

    always_comb begin
        srtt_s   = $signed(srtt_reg);
        var_s    = $signed(var_reg);
        srtt_sh  = srtt_s >>> 3;
        var_sh   = var_s >>> 2;
        base_rto = 16'(srtt_sh) + var_reg;
        cw0      = rec_reg ? ss_reg : cw_reg;
        half     = (snd_max_reg - last_reg) >> 1;
        floor2   = {mss_reg, 1'b0};
        mss3     = {1'b0, mss_reg, 1'b0} + {2'b00, mss_reg};
        dc_inc   = (dc_reg == DUP_COUNT_MAX) ? dc_reg : dc_reg + 8'd1;
        rem_sh   = {divr_reg, divq_reg[31]};
        elapsed  = now_reg - rtick_reg;
        m_val    = {{2{elapsed[31]}}, elapsed} - 34'(srtt_sh);
        m_abs    = m_val[33] ? -m_val : m_val;
        var_n    = var_reg + mabs_reg - 16'(var_sh);
        srtt_n_s = $signed(srtt_reg) >>> 3;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: begin
                if (cmd_reg == CMD_SEGMENT && ackf_reg) begin
                    state_next = ST_RTT_A;
                    if (last_reg != ack_in_reg && seq_before(last_reg, ack_in_reg) &&
                        (ack_in_reg == snd_max_reg || seq_before(ack_in_reg, snd_max_reg)) &&
                        est_reg && !(cw0 < ss_reg) && cw0 != 32'd0) begin
                        state_next = ST_DIV;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:   if (cnt_reg == '1) state_next = ST_GROW;
            ST_GROW:  state_next = ST_RTT_A;
            ST_RTT_A: begin
                if (ract_reg && seq_before(rseq_reg, ack_in_reg)) state_next = ST_RTT_B;
                else state_next = ST_OUT;
            end
            ST_RTT_B: state_next = ST_OUT;
            ST_OUT:   if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        mss_next  = mss_reg;   ivar_next = ivar_reg;
        pw_next   = pw_reg;    wsm_next  = wsm_reg;   wam_next  = wam_reg;
        last_next = last_reg;  dc_next   = dc_reg;    cw_next   = cw_reg;
        ss_next   = ss_reg;    rec_next  = rec_reg;   srtt_next = srtt_reg;
        var_next  = var_reg;   rto_next  = rto_reg;   ract_next = ract_reg;
        rseq_next = rseq_reg;  rtick_next = rtick_reg;
        divq_next = divq_reg;  divr_next = divr_reg;  divd_next = divd_reg;
        cnt_next  = cnt_reg;   mabs_next = mabs_reg;
        acked_next = acked_reg; fast_next = fast_reg; newack_next = newack_reg;
        wupd_next = wupd_reg;  samp_next = samp_reg;

        if (cfg_wr_en) begin
            if (cfg_index == CFG_IDX_MSS) mss_next = cfg_wdata;
            if (cfg_index == CFG_IDX_RTTVAR) ivar_next = cfg_wdata[RTTVAR_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    acked_next = '0; fast_next = 1'b0; newack_next = 1'b0;
                    wupd_next = 1'b0; samp_next = 1'b0;
                end
            end
            ST_EXEC: begin
                if (cmd_reg == CMD_RTT_START) begin
                    ract_next  = 1'b1;
                    rseq_next  = seq_in_reg;
                    rtick_next = now_reg;
                end else if (cmd_reg == CMD_INIT) begin
                    pw_next   = wnd_reg;
                    ss_next   = {16'd0, wnd_reg};
                    wsm_next  = seq_in_reg;
                    wam_next  = ack_in_reg;
                    last_next = ack_in_reg;
                    cw_next   = {16'd0, mss_reg};
                    dc_next   = '0;
                    rec_next  = 1'b0;
                    srtt_next = '0;
                    var_next  = {1'b0, ivar_reg};
                    rto_next  = {1'b0, ivar_reg};
                    ract_next = 1'b0;
                end else if (cmd_reg == CMD_SEGMENT && ackf_reg) begin
                    if (seq_before(wsm_reg, seq_in_reg) ||
                        (wsm_reg == seq_in_reg && seq_before(wam_reg, ack_in_reg)) ||
                        (wam_reg == ack_in_reg && wnd_reg > pw_reg)) begin
                        pw_next   = wnd_reg;
                        wsm_next  = seq_in_reg;
                        wam_next  = ack_in_reg;
                        wupd_next = 1'b1;
                    end
                    if (last_reg == ack_in_reg) begin
                        dc_next = dc_inc;
                        if (dc_inc >= DUP_THRESHOLD && unacked_reg) begin
                            if (!rec_reg) begin
                                fast_next = 1'b1;
                                ss_next   = (half > {15'd0, floor2}) ? half : {15'd0, floor2};
                                cw_next   = add_sat((half > {15'd0, floor2}) ? half
                                                    : {15'd0, floor2}, {15'd0, mss3});
                                rec_next  = 1'b1;
                            end else begin
                                cw_next = add_sat(cw_reg, {17'd0, mss_reg});
                            end
                        end
                    end else if (seq_before(last_reg, ack_in_reg) &&
                                 (ack_in_reg == snd_max_reg ||
                                  seq_before(ack_in_reg, snd_max_reg))) begin
                        newack_next = 1'b1;
                        rec_next    = 1'b0;
                        rto_next    = base_rto;
                        acked_next  = 16'(ack_in_reg - last_reg);
                        dc_next     = '0;
                        last_next   = ack_in_reg;
                        cw_next     = cw0;
                        if (est_reg) begin
                            if (cw0 < ss_reg || cw0 == 32'd0) begin
                                cw_next = add_sat(cw0, {17'd0, mss_reg});
                            end else begin
                                divq_next = {16'd0, mss_reg} * {16'd0, mss_reg};
                                divr_next = '0;
                                divd_next = cw0;
                                cnt_next  = '0;
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (rem_sh >= {1'b0, divd_reg}) begin
                    divr_next = 32'(rem_sh - {1'b0, divd_reg});
                    divq_next = {divq_reg[30:0], 1'b1};
                end else begin
                    divr_next = rem_sh[31:0];
                    divq_next = {divq_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_GROW: cw_next = add_sat(cw_reg, {1'b0, divq_reg});
            ST_RTT_A: begin
                if (ract_reg && seq_before(rseq_reg, ack_in_reg)) begin
                    srtt_next = srtt_reg + m_val[15:0];
                    mabs_next = m_abs[15:0];
                    ract_next = 1'b0;
                    samp_next = 1'b1;
                end
            end
            ST_RTT_B: begin
                var_next = var_n;
                rto_next = 16'(srtt_n_s) + var_n;
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mss_reg <= 16'd536;  ivar_reg <= 15'd6;
            pw_reg <= '0;  wsm_reg <= '0;  wam_reg <= '0;  last_reg <= '0;
            dc_reg <= '0;  cw_reg <= '0;   ss_reg <= '0;   rec_reg <= 1'b0;
            srtt_reg <= '0; var_reg <= '0; rto_reg <= '0;  ract_reg <= 1'b0;
            rseq_reg <= '0; rtick_reg <= '0;
            cnt_reg <= '0;
            acked_reg <= '0; fast_reg <= 1'b0; newack_reg <= 1'b0;
            wupd_reg <= 1'b0; samp_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mss_reg <= mss_next;  ivar_reg <= ivar_next;
            pw_reg <= pw_next;  wsm_reg <= wsm_next;  wam_reg <= wam_next;
            last_reg <= last_next;
            dc_reg <= dc_next;  cw_reg <= cw_next;  ss_reg <= ss_next;
            rec_reg <= rec_next;
            srtt_reg <= srtt_next; var_reg <= var_next; rto_reg <= rto_next;
            ract_reg <= ract_next;
            rseq_reg <= rseq_next; rtick_reg <= rtick_next;
            cnt_reg <= cnt_next;
            acked_reg <= acked_next; fast_reg <= fast_next; newack_reg <= newack_next;
            wupd_reg <= wupd_next; samp_reg <= samp_next;
        end
    end

    // Payload, scratch and divider data registers carry no reset.
    always_ff @(posedge aclk) begin
        divq_reg <= divq_next;
        divr_reg <= divr_next;
        divd_reg <= divd_next;
        mabs_reg <= mabs_next;
        if (accept) begin
            cmd_reg     <= s_command;
            seq_in_reg  <= s_seq_number;
            ack_in_reg  <= s_ack_number;
            wnd_reg     <= s_window;
            ackf_reg    <= s_ack_flag;
            snd_max_reg <= s_highest_sent;
            unacked_reg <= s_unacked_present;
            est_reg     <= s_connection_established;
            now_reg     <= s_now_tick;
        end
    end

    // Handshake and result outputs.
    always_comb begin
        s_ready                = (state_reg == ST_IDLE);
        m_valid                = (state_reg == ST_OUT);
        m_send_window          = pw_reg;
        m_congestion_window    = cw_reg;
        m_slow_start_threshold = ss_reg;
        m_retransmit_timeout   = $signed(rto_reg);
        m_acked_bytes          = acked_reg;
        m_fast_retransmit      = fast_reg;
        m_new_data_acked       = newack_reg;
        m_window_updated       = wupd_reg;
        m_rtt_sampled          = samp_reg;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("result pending while accepting");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accepted two transactions");
    a_acked_needs_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_acked_bytes != 16'd0) |-> m_new_data_acked)
        else $error("acked bytes without new ack");
    a_fast_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fast_retransmit) |-> !m_new_data_acked)
        else $error("fast retransmit on new ack");

endmodule
